// ===== rtl/ess_pkg.sv =====
// shared constants and types for the exchange sort engine
// no dependencies
package ess_pkg;

   localparam int DEPTH   = 1024;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int POS_W   = 10;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic                      wr_en;
      logic [IDX_W-1:0]          wr_addr;
      logic signed [VALUE_W-1:0] wr_data;
      logic                      rd_en;
      logic [IDX_W-1:0]          rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] n;
   } sort_cmd_type;

endpackage

// ===== rtl/exchange_sort_engine.sv =====
// exchange sort engine top level: load/read handshake, counters, result register
// depends on ess_pkg and ess_sorter
//
//   channel  dir  ports                                    carries
//   req      in   req_valid/ready, kind, value, last       one load or read word
//   rsp      out  rsp_valid/ready, value_res, position,    one word per read
//                 final_res, empty_res, overflow
//
// load word: written to the store on acceptance; read word: waits in T_READ if the result is not taken
// sort after the last load: the n loaded entries are sorted in place, at most one read and at
// most one write of the store a cycle
// reset clears counters and flags only; the store holds nothing valid until loaded
// req_ready stays low during a sort and while a read waits for the result register
module exchange_sort_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic signed [ess_pkg::VALUE_W-1:0]  req_value,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ess_pkg::VALUE_W-1:0]  rsp_value_res,
   output logic [ess_pkg::POS_W-1:0]           rsp_position,
   output logic                                rsp_final_res,
   output logic                                rsp_empty_res,
   output logic                                rsp_overflow
);
   import ess_pkg::*;

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_READ = 2'd1;
   localparam logic [1:0] T_SORT = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          rp_ff, rp_in;
   logic                      sorted_ff, sorted_in;
   logic                      dropped_ff, dropped_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]          rsp_pos_ff, rsp_pos_in;
   logic                      rsp_final_ff, rsp_final_in;
   logic                      rsp_empty_ff, rsp_empty_in;
   logic                      rsp_ovf_ff, rsp_ovf_in;

   logic                      accept;
   logic [CNT_W-1:0]          count_base;
   logic                      full;
   logic                      empty;
   logic                      slot_free;
   logic                      sorter_busy;
   logic signed [VALUE_W-1:0] rd_data;
   mem_req_type               host_req;
   sort_cmd_type              cmd;

   assign req_ready  = (state_ff == T_IDLE);
   assign accept     = req_valid && req_ready;
   assign count_base = sorted_ff ? '0 : count_ff;
   assign full       = (count_base == CNT_W'(DEPTH));
   assign empty      = !sorted_ff || (rp_ff >= count_ff);
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rp_in        = rp_ff;
      sorted_in    = sorted_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_final_in = rsp_final_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      host_req     = '0;
      cmd          = '0;
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_LOAD) begin
                  sorted_in  = 1'b0;
                  rp_in      = sorted_ff ? '0 : rp_ff;
                  dropped_in = (dropped_ff && !sorted_ff) || full;
                  count_in   = count_base;
                  if (!full) begin
                     host_req.wr_en   = 1'b1;
                     host_req.wr_addr = count_base[IDX_W-1:0];
                     host_req.wr_data = req_value;
                     count_in         = count_base + CNT_W'(1);
                  end
                  if (req_last) begin
                     cmd.start = 1'b1;
                     cmd.n     = count_in;
                     rp_in     = '0;
                     state_in  = T_SORT;
                  end
               end else begin
                  host_req.rd_en   = 1'b1;
                  host_req.rd_addr = rp_ff[IDX_W-1:0];
                  state_in         = T_READ;
               end
            end
         end
         T_READ: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = empty ? '0 : rd_data;
               rsp_pos_in   = empty ? '0 : POS_W'(rp_ff);
               rsp_final_in = !empty && ((rp_ff + CNT_W'(1)) == count_ff);
               rsp_empty_in = empty;
               rsp_ovf_in   = dropped_ff;
               if (!empty) begin
                  rp_in = rp_ff + CNT_W'(1);
               end
               state_in = T_IDLE;
            end
         end
         T_SORT: begin
            if (!sorter_busy) begin
               sorted_in = 1'b1;
               state_in  = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         count_ff     <= '0;
         rp_ff        <= '0;
         sorted_ff    <= 1'b0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rp_ff        <= rp_in;
         sorted_ff    <= sorted_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_final_ff <= rsp_final_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   ess_sorter u_sorter (
      .clock    (clock),
      .reset    (reset),
      .host_req (host_req),
      .cmd      (cmd),
      .busy     (sorter_busy),
      .rd_data  (rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_position  = rsp_pos_ff;
   assign rsp_final_res = rsp_final_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_overflow  = rsp_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNT_W'(DEPTH)) && (rp_ff <= count_ff))
      else $error("count or read pointer out of range");

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      sorter_busy |-> (state_ff == T_SORT))
      else $error("word accepted during sort");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_value_ff == '0 && !rsp_final_ff))
      else $error("empty word carries data");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == T_READ))
      else $error("result word without a read");

endmodule

// ===== rtl/ess_sorter.sv =====
// value store with the in-place exchange sort sequencer
// depends on ess_pkg; host port reaches the store while the sequencer is idle
module ess_sorter (
   input  logic                             clock,
   input  logic                             reset,
   input  ess_pkg::mem_req_type             host_req,
   input  ess_pkg::sort_cmd_type            cmd,
   output logic                             busy,
   output logic signed [ess_pkg::VALUE_W-1:0] rd_data
);
   import ess_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOADI  = 3'd1;
   localparam logic [2:0] S_FIRST  = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_WRITEI = 3'd4;

   logic signed [VALUE_W-1:0] store_mem [DEPTH];

   logic [2:0]                state_ff, state_in;
   logic [CNT_W-1:0]          i_ff, i_in;
   logic [CNT_W-1:0]          j_ff, j_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic signed [VALUE_W-1:0] ai_ff, ai_in;
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic [CNT_W-1:0]          j_next;
   logic [CNT_W-1:0]          i_next;
   logic                      swap;
   mem_req_type               port;

   assign j_next = j_ff + CNT_W'(1);
   assign i_next = i_ff + CNT_W'(1);
   assign swap   = (j_ff != i_ff) && (ai_ff < rd_data_ff);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      n_in     = n_ff;
      ai_in    = ai_ff;
      port     = '0;
      unique case (state_ff)
         S_IDLE: begin
            port = host_req;
            if (cmd.start) begin
               i_in     = '0;
               n_in     = cmd.n;
               state_in = S_LOADI;
            end
         end
         S_LOADI: begin
            port.rd_en   = 1'b1;
            port.rd_addr = i_ff[IDX_W-1:0];
            state_in     = S_FIRST;
         end
         S_FIRST: begin
            ai_in        = rd_data_ff;
            port.rd_en   = 1'b1;
            port.rd_addr = '0;
            j_in         = '0;
            state_in     = S_SCAN;
         end
         S_SCAN: begin
            if (swap) begin
               port.wr_en   = 1'b1;
               port.wr_addr = j_ff[IDX_W-1:0];
               port.wr_data = ai_ff;
               ai_in        = rd_data_ff;
            end
            if (j_next < n_ff) begin
               port.rd_en   = 1'b1;
               port.rd_addr = j_next[IDX_W-1:0];
               j_in         = j_next;
            end else begin
               state_in = S_WRITEI;
            end
         end
         S_WRITEI: begin
            port.wr_en   = 1'b1;
            port.wr_addr = i_ff[IDX_W-1:0];
            port.wr_data = ai_ff;
            i_in         = i_next;
            state_in     = (i_next < n_ff) ? S_LOADI : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff  <= i_in;
      j_ff  <= j_in;
      n_ff  <= n_in;
      ai_ff <= ai_in;
   end

   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         store_mem[port.wr_addr] <= port.wr_data;
      end
      if (port.rd_en) begin
         rd_data_ff <= store_mem[port.rd_addr];
      end
   end

   assign busy    = (state_ff != S_IDLE);
   assign rd_data = rd_data_ff;

   // scan never writes the outer entry, it is held in ai until the pass ends
   a_no_outer_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && port.wr_en) |-> (j_ff != i_ff))
      else $error("scan wrote the outer entry");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (j_ff < n_ff && i_ff < n_ff))
      else $error("scan index out of range");

   a_pass_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITEI) |=> (state_ff == S_LOADI || state_ff == S_IDLE))
      else $error("bad step after outer write");

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for exchange_sort_engine: load/sort/read words against a shadow sort
// depends on ess_pkg and the exchange_sort_engine rtl
// random stimulus, random idling on both channels, watchdog on stalled handshakes
module tb_top;
   import ess_pkg::*;

   localparam int STUCK_LIMIT = 4 * DEPTH * (DEPTH + 3) + 10000;
   localparam int TAIL_CYCLES = 16;
   localparam int RANDOM_WORDS = 580;

   typedef struct {
      logic                      kind;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      bit                        hold;
   } req_word_type;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
      logic                      final_res;
      logic                      empty_res;
      logic                      overflow;
   } read_result_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_kind = KIND_LOAD;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      req_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_value_res;
   logic [POS_W-1:0]          rsp_position;
   logic                      rsp_final_res;
   logic                      rsp_empty_res;
   logic                      rsp_overflow;

   req_word_type    pending_words[$];
   read_result_type reads_due[$];

   logic signed [VALUE_W-1:0] shadow_store [DEPTH];
   int  shadow_count = 0;
   int  shadow_rd_ptr = 0;
   bit  shadow_sorted = 1'b0;
   bit  shadow_dropped = 1'b0;

   int          send_gap_left = 0;
   int          recv_stall_left = 0;
   int          reads_outstanding = 0;
   int          mismatch_cnt = 0;
   int          stuck_cycles = 0;
   logic        stim_done = 1'b0;
   logic [31:0] cycle_cnt = '0;
   logic        calm;

   assign calm = (cycle_cnt[9:8] == 2'b00);

   exchange_sort_engine i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_res (rsp_value_res),
      .rsp_position  (rsp_position),
      .rsp_final_res (rsp_final_res),
      .rsp_empty_res (rsp_empty_res),
      .rsp_overflow  (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic sort_shadow();
      int i;
      int j;
      logic signed [VALUE_W-1:0] t;
      for (i = 0; i < shadow_count; i++) begin
         for (j = 0; j < shadow_count; j++) begin
            if (shadow_store[i] < shadow_store[j]) begin
               t = shadow_store[i];
               shadow_store[i] = shadow_store[j];
               shadow_store[j] = t;
            end
         end
      end
   endtask

   task automatic apply_word(input req_word_type w);
      read_result_type r;
      if (w.kind == KIND_LOAD) begin
         if (shadow_sorted) begin
            shadow_count = 0;
            shadow_rd_ptr = 0;
            shadow_sorted = 1'b0;
            shadow_dropped = 1'b0;
         end
         if (shadow_count < DEPTH) begin
            shadow_store[shadow_count] = w.value;
            shadow_count++;
         end else begin
            shadow_dropped = 1'b1;
         end
         if (w.last) begin
            sort_shadow();
            shadow_sorted = 1'b1;
            shadow_rd_ptr = 0;
         end
      end else begin
         r.overflow = shadow_dropped;
         if (!shadow_sorted || shadow_rd_ptr >= shadow_count) begin
            r.value = '0;
            r.position = '0;
            r.final_res = 1'b0;
            r.empty_res = 1'b1;
         end else begin
            r.value = shadow_store[shadow_rd_ptr];
            r.position = shadow_rd_ptr[POS_W-1:0];
            r.final_res = (shadow_rd_ptr + 1 == shadow_count);
            r.empty_res = 1'b0;
            shadow_rd_ptr++;
         end
         reads_due.push_back(r);
      end
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: pick_value = 32'h8000_0000;
         1: pick_value = 32'h7fff_ffff;
         2: pick_value = $signed($urandom_range(0, 6)) - 3;
         default: pick_value = $urandom;
      endcase
   endfunction

   task automatic add_load(input logic signed [VALUE_W-1:0] v, input logic last, input bit hold);
      req_word_type w;
      w.kind = KIND_LOAD;
      w.value = v;
      w.last = last;
      w.hold = hold;
      pending_words.push_back(w);
   endtask

   task automatic add_read();
      req_word_type w;
      w.kind = KIND_READ;
      w.value = $urandom;
      w.last = $urandom_range(0, 1);
      w.hold = 1'b0;
      pending_words.push_back(w);
   endtask

   task automatic build_stimulus();
      int i;
      int n;
      int m;
      int start;
      req_word_type w;

      // read before any sort, extremes, single entry, duplicates
      add_read();
      add_load(32'h8000_0000, 1'b0, 1'b0);
      add_load(32'h7fff_ffff, 1'b0, 1'b0);
      add_load(32'h0000_0000, 1'b0, 1'b0);
      add_load(32'hffff_ffff, 1'b0, 1'b0);
      add_load(32'h0000_0001, 1'b1, 1'b0);
      repeat (6) add_read();
      add_load(32'sd7, 1'b1, 1'b0);
      repeat (2) add_read();
      add_load(32'sd5, 1'b0, 1'b0);
      add_load(32'sd5, 1'b0, 1'b0);
      add_load(-32'sd5, 1'b1, 1'b0);
      repeat (3) add_read();

      // full store, dropped loads, last on a dropped load
      for (i = 0; i <= DEPTH; i++) add_load(pick_value(), 1'b0, 1'b0);
      add_read();
      add_load(pick_value(), 1'b1, 1'b0);
      repeat (DEPTH + 1) add_read();

      // sender waits for all reads before a held load: this first one and some set starts below
      start = pending_words.size();
      add_load(pick_value(), 1'b0, 1'b1);
      while (pending_words.size() - start < RANDOM_WORDS) begin
         case ($urandom_range(0, 9))
            7: begin
               repeat ($urandom_range(1, 4)) begin
                  w.kind = $urandom_range(0, 1);
                  w.value = pick_value();
                  w.last = $urandom_range(0, 1);
                  w.hold = 1'b0;
                  pending_words.push_back(w);
               end
            end
            8: begin
               repeat ($urandom_range(1, 3)) add_load(pick_value(), 1'b0, 1'b0);
               repeat ($urandom_range(1, 2)) add_read();
            end
            9: begin
               repeat ($urandom_range(1, 3)) add_read();
            end
            default: begin
               n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
               for (i = 0; i < n; i++)
                  add_load(pick_value(), i == n - 1, i == 0 && $urandom_range(0, 9) == 0);
               m = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1)
                                                : n + $urandom_range(0, 2);
               repeat (m) add_read();
            end
         endcase
      end
   endtask

   always @(posedge clock) begin : driver
      int gap;
      req_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap_left <= 0;
      end else if (req_valid && req_ready) begin
         gap = calm ? 0 : $urandom_range(0, 4);
         if (gap == 0 && pending_words.size() != 0 && !pending_words[0].hold) begin
            w = pending_words.pop_front();
            req_kind <= w.kind;
            req_value <= w.value;
            req_last <= w.last;
         end else begin
            req_valid <= 1'b0;
            send_gap_left <= gap;
         end
      end else if (!req_valid) begin
         if (send_gap_left != 0) begin
            send_gap_left <= send_gap_left - 1;
         end else if (pending_words.size() != 0 &&
                      (!pending_words[0].hold || reads_outstanding == 0)) begin
            w = pending_words.pop_front();
            req_kind <= w.kind;
            req_value <= w.value;
            req_last <= w.last;
            req_valid <= 1'b1;
         end else if (pending_words.size() == 0) begin
            stim_done <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : monitor
      read_result_type want;
      req_word_type seen;
      int stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall_left <= 0;
         reads_outstanding <= 0;
      end else begin
         if (req_valid && req_ready) begin
            seen.kind = req_kind;
            seen.value = req_value;
            seen.last = req_last;
            seen.hold = 1'b0;
            apply_word(seen);
         end
         if (rsp_valid && rsp_ready) begin
            if (reads_due.size() == 0) begin
               if (mismatch_cnt < 10)
                  $display("unexpected word: value %0d pos %0d final %0b empty %0b ovf %0b",
                           rsp_value_res, rsp_position, rsp_final_res, rsp_empty_res,
                           rsp_overflow);
               mismatch_cnt++;
            end else begin
               want = reads_due.pop_front();
               if (rsp_value_res !== want.value || rsp_position !== want.position ||
                   rsp_final_res !== want.final_res || rsp_empty_res !== want.empty_res ||
                   rsp_overflow !== want.overflow) begin
                  if (mismatch_cnt < 10)
                     $display({"mismatch: expected value %0d pos %0d final %0b empty %0b",
                               " ovf %0b, got value %0d pos %0d final %0b empty %0b ovf %0b"},
                              want.value, want.position, want.final_res, want.empty_res,
                              want.overflow, rsp_value_res, rsp_position, rsp_final_res,
                              rsp_empty_res, rsp_overflow);
                  mismatch_cnt++;
               end
            end
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
               rsp_ready <= 1'b0;
               recv_stall_left <= stall - 1;
            end
         end else if (!rsp_ready) begin
            if (recv_stall_left == 0)
               rsp_ready <= 1'b1;
            else
               recv_stall_left <= recv_stall_left - 1;
         end
         reads_outstanding <= reads_due.size();
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   initial begin
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   initial begin
      build_stimulus();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (!stim_done || reads_outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0 && reads_outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ess_pkg.sv
rtl/ess_sorter.sv
rtl/exchange_sort_engine.sv
test/tb_top.sv
